@@ design/obptm_pkg.sv @@
`default_nettype none

package obptm_pkg;

  localparam int PRICE_W  = 10;
  localparam int AMOUNT_W = 32;
  localparam int IDENT_W  = 32;
  localparam int SLOT_W   = 12;
  localparam int ORDERS_W = 13;
  localparam int VOLUME_W = 44;

  localparam int TICK_COUNT_DEF = 1024;
  localparam int NODE_COUNT_DEF = 4096;
  localparam int FILL_LIMIT_DEF = 64;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_MATCH = 1'b1;
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef struct packed {
    logic                op;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [AMOUNT_W-1:0] amount;
    logic [IDENT_W-1:0]  ident;
    logic [SLOT_W-1:0]   slot;
  } in_item_t;

  typedef struct packed {
    logic                fill_valid;
    logic [IDENT_W-1:0]  maker_ident;
    logic [IDENT_W-1:0]  taker_ident;
    logic [PRICE_W-1:0]  fill_price;
    logic [AMOUNT_W-1:0] fill_amount;
    logic [AMOUNT_W-1:0] left_over;
    logic                last;
  } res_item_t;

  typedef struct packed {
    logic clr_we;
    logic lat_in;
    logic lvl_re;
    logic add_node;
    logic add_link;
    logic emit_ack;
    logic scan_reset;
    logic scan_next;
    logic scan_hit;
    logic head_null_wr;
    logic node_re;
    logic fill_do;
    logic emit_fin;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_match;
    logic add_ok;
    logic tail_null;
    logic rem_zero;
    logic n_full;
    logic word_nz;
    logic crosses;
    logic scan_last;
    logic head_null;
    logic cont;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/obptm_ctrl.sv @@
`default_nettype none

module obptm_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  obptm_pkg::dp_stat_t stat_i,
  output obptm_pkg::dp_cmd_t  cmd_o,
  output logic                busy_o
);
  import obptm_pkg::*;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_ADD_RD   = 4'd2;
  localparam logic [3:0] S_ADD_NODE = 4'd3;
  localparam logic [3:0] S_ADD_LINK = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_LVL_RD   = 4'd7;
  localparam logic [3:0] S_HEAD     = 4'd8;
  localparam logic [3:0] S_NODE     = 4'd9;
  localparam logic [3:0] S_FIN      = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_we = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.lat_in = 1'b1;
          state_d = stat_i.is_match ? S_CHECK : S_ADD_RD;
        end
      end
      S_ADD_RD: begin
        if (stat_i.add_ok) begin
          cmd_o.lvl_re = 1'b1;
          state_d = S_ADD_NODE;
        end else begin
          cmd_o.emit_ack = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ADD_NODE: begin
        cmd_o.add_node = 1'b1;
        state_d = S_ADD_LINK;
      end
      S_ADD_LINK: begin
        cmd_o.add_link = !stat_i.tail_null;
        cmd_o.emit_ack = 1'b1;
        state_d = S_IDLE;
      end
      S_CHECK: begin
        if (stat_i.rem_zero || stat_i.n_full) begin
          state_d = S_FIN;
        end else begin
          cmd_o.scan_reset = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.word_nz) begin
          if (stat_i.crosses) begin
            cmd_o.scan_hit = 1'b1;
            state_d = S_LVL_RD;
          end else begin
            state_d = S_FIN;
          end
        end else if (stat_i.scan_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_LVL_RD: begin
        cmd_o.lvl_re = 1'b1;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        if (stat_i.head_null) begin
          cmd_o.head_null_wr = 1'b1;
          state_d = S_CHECK;
        end else begin
          cmd_o.node_re = 1'b1;
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        cmd_o.fill_do = 1'b1;
        state_d = stat_i.cont ? S_HEAD : S_CHECK;
      end
      S_FIN: begin
        cmd_o.emit_fin = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ design/obptm_dp.sv @@
`default_nettype none

module obptm_dp #(
  parameter int TICK_COUNT = obptm_pkg::TICK_COUNT_DEF,
  parameter int NODE_COUNT = obptm_pkg::NODE_COUNT_DEF,
  parameter int FILL_LIMIT = obptm_pkg::FILL_LIMIT_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  obptm_pkg::in_item_t  item_i,
  input  obptm_pkg::dp_cmd_t   cmd_i,
  output obptm_pkg::dp_stat_t  stat_o,
  output obptm_pkg::res_item_t result_o,
  output logic                 res_valid_o
);
  import obptm_pkg::*;

  localparam int WPS       = (TICK_COUNT + 63) / 64;
  localparam int OCC_WORDS = 2 * WPS;
  localparam int OW        = $clog2(OCC_WORDS);
  localparam int SW        = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int TKW       = $clog2(WPS * 64);
  localparam int LVL_DEPTH = 2 * TICK_COUNT;
  localparam int LW        = $clog2(LVL_DEPTH);
  localparam int NW        = $clog2(NODE_COUNT + 1);
  localparam int AW        = $clog2(NODE_COUNT);
  localparam int CW        = $clog2(FILL_LIMIT + 1);
  localparam logic [NW-1:0] EMPTY_PTR = NW'(NODE_COUNT);

  // Level and node stores.
  logic [NW-1:0]       head_mem [LVL_DEPTH];
  logic [NW-1:0]       tail_mem [LVL_DEPTH];
  logic [ORDERS_W-1:0] ord_mem  [LVL_DEPTH];
  logic [VOLUME_W-1:0] vol_mem  [LVL_DEPTH];
  logic [AMOUNT_W-1:0] amt_mem  [NODE_COUNT];
  logic [IDENT_W-1:0]  id_mem   [NODE_COUNT];
  logic [NW-1:0]       link_mem [NODE_COUNT];

  logic [63:0] occ_q [OCC_WORDS];

  in_item_t            in_q;
  logic [AMOUNT_W-1:0] rem_q, rem_d;
  logic [CW-1:0]       cnt_q;
  logic [SW-1:0]       scan_q;
  logic [TKW-1:0]      t_q;
  logic [LW-1:0]       li_q, clr_q;
  logic [NW-1:0]       lh_q, lt_q;
  logic [ORDERS_W-1:0] lo_q;
  logic [VOLUME_W-1:0] lv_q;
  logic [AMOUNT_W-1:0] na_q;
  logic [IDENT_W-1:0]  ni_q;
  logic [NW-1:0]       nl_q;
  res_item_t           pend_q, res_q, res_d;
  logic                pend_vld_q, strobe_q;

  // Scan of the opposite side's bitmap, one word per cycle.
  logic           ms, bside;
  logic [SW-1:0]  scan_w;
  logic [OW-1:0]  scan_idx, bit_idx;
  logic [63:0]    scan_v;
  logic [5:0]     hit_bit;
  logic [TKW-1:0] t_scan;
  logic [LW-1:0]  li_scan, li_in;

  assign ms       = ~in_q.side;
  assign scan_w   = (in_q.side == SIDE_ASK) ? (SW'(WPS - 1) - scan_q) : scan_q;
  assign scan_idx = OW'(ms ? WPS : 0) + OW'(scan_w);
  assign scan_v   = occ_q[scan_idx];

  always_comb begin
    hit_bit = '0;
    if (in_q.side == SIDE_ASK) begin
      for (int i = 0; i < 64; i++) begin
        if (scan_v[i]) hit_bit = 6'(i);
      end
    end else begin
      for (int i = 63; i >= 0; i--) begin
        if (scan_v[i]) hit_bit = 6'(i);
      end
    end
  end

  assign t_scan  = TKW'((TKW'(scan_w) << 6) | TKW'(hit_bit));
  assign li_scan = LW'(ms ? TICK_COUNT : 0) + LW'(t_scan);
  assign li_in   = LW'(item_i.side ? TICK_COUNT : 0) + LW'(item_i.price);

  // Fill arithmetic on the head order.
  logic                full, nx_null;
  logic [AMOUNT_W-1:0] fill_amt;
  logic [CW-1:0]       cnt_inc;

  assign full     = (na_q <= rem_q);
  assign fill_amt = full ? na_q : rem_q;
  assign rem_d    = rem_q - fill_amt;
  assign nx_null  = (nl_q >= EMPTY_PTR);
  assign cnt_inc  = cnt_q + CW'(1);

  // Level entry next value.
  logic [NW-1:0]       wh, wt;
  logic [ORDERS_W-1:0] wo;
  logic [VOLUME_W-1:0] wv;
  logic                lvl_we;
  logic [LW-1:0]       lvl_wa;

  always_comb begin
    wh = lh_q;
    wt = lt_q;
    wo = lo_q;
    wv = lv_q;
    priority if (cmd_i.clr_we) begin
      wh = EMPTY_PTR;
      wt = EMPTY_PTR;
      wo = '0;
      wv = '0;
    end else if (cmd_i.add_node) begin
      wh = (lt_q >= EMPTY_PTR) ? NW'(in_q.slot) : lh_q;
      wt = NW'(in_q.slot);
      wo = lo_q + ORDERS_W'(1);
      wv = lv_q + VOLUME_W'(in_q.amount);
    end else if (cmd_i.head_null_wr) begin
      wh = EMPTY_PTR;
      wt = EMPTY_PTR;
    end else if (cmd_i.fill_do) begin
      wv = lv_q - VOLUME_W'(fill_amt);
      if (full) begin
        wh = nx_null ? EMPTY_PTR : nl_q;
        wt = nx_null ? EMPTY_PTR : lt_q;
        wo = lo_q - ORDERS_W'(1);
      end
    end
  end

  assign lvl_we = cmd_i.clr_we | cmd_i.add_node | cmd_i.head_null_wr | cmd_i.fill_do;
  assign lvl_wa = cmd_i.clr_we ? clr_q : li_q;

  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      head_mem[lvl_wa] <= wh;
      tail_mem[lvl_wa] <= wt;
      ord_mem[lvl_wa]  <= wo;
      vol_mem[lvl_wa]  <= wv;
    end
    if (cmd_i.lvl_re) begin
      lh_q <= head_mem[li_q];
      lt_q <= tail_mem[li_q];
      lo_q <= ord_mem[li_q];
      lv_q <= vol_mem[li_q];
    end else if (cmd_i.fill_do) begin
      lh_q <= wh;
      lt_q <= wt;
      lo_q <= wo;
      lv_q <= wv;
    end
  end

  // Node store: one write per array per cycle, registered read at the head.
  logic          link_we, amt_we;
  logic [AW-1:0] link_wa, amt_wa, head_a;
  logic [NW-1:0] link_wd;
  logic [AMOUNT_W-1:0] amt_wd;

  assign head_a  = AW'(lh_q);
  assign link_we = cmd_i.add_node | cmd_i.add_link | (cmd_i.fill_do & full);
  assign link_wa = cmd_i.add_link ? AW'(lt_q) : (cmd_i.add_node ? AW'(in_q.slot) : head_a);
  assign link_wd = cmd_i.add_link ? NW'(in_q.slot) : EMPTY_PTR;
  assign amt_we  = cmd_i.add_node | (cmd_i.fill_do & !full);
  assign amt_wa  = cmd_i.add_node ? AW'(in_q.slot) : head_a;
  assign amt_wd  = cmd_i.add_node ? in_q.amount : (na_q - rem_q);

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (amt_we) amt_mem[amt_wa] <= amt_wd;
    if (cmd_i.add_node) id_mem[AW'(in_q.slot)] <= in_q.ident;
    if (cmd_i.node_re) begin
      na_q <= amt_mem[head_a];
      ni_q <= id_mem[head_a];
      nl_q <= link_mem[head_a];
    end
  end

  // Occupancy bitmap.
  assign bside   = (in_q.op == OP_ADD) ? in_q.side : ms;
  assign bit_idx = OW'(bside ? WPS : 0) + OW'(t_q >> 6);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OCC_WORDS; i++) occ_q[i] <= '0;
    end else if (cmd_i.add_node) begin
      occ_q[bit_idx][t_q[5:0]] <= 1'b1;
    end else if (cmd_i.head_null_wr || (cmd_i.fill_do && full && nx_null)) begin
      occ_q[bit_idx][t_q[5:0]] <= 1'b0;
    end
  end

  // Item and sweep registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      if (cmd_i.clr_we) clr_q <= clr_q + LW'(1);
      if (cmd_i.lat_in) pend_vld_q <= 1'b0;
      else if (cmd_i.fill_do) pend_vld_q <= 1'b1;
      strobe_q <= cmd_i.emit_ack | cmd_i.emit_fin | (cmd_i.fill_do & pend_vld_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_in) begin
      in_q  <= item_i;
      rem_q <= item_i.amount;
      cnt_q <= '0;
      t_q   <= TKW'(item_i.price);
      li_q  <= li_in;
    end
    if (cmd_i.scan_reset) scan_q <= '0;
    else if (cmd_i.scan_next) scan_q <= scan_q + SW'(1);
    if (cmd_i.scan_hit) begin
      t_q  <= t_scan;
      li_q <= li_scan;
    end
    if (cmd_i.fill_do) begin
      rem_q  <= rem_d;
      cnt_q  <= cnt_inc;
      pend_q <= '{fill_valid: 1'b1, maker_ident: ni_q, taker_ident: in_q.ident,
                  fill_price: PRICE_W'(t_q), fill_amount: fill_amt,
                  left_over: '0, last: 1'b0};
    end
    if (cmd_i.emit_ack || cmd_i.emit_fin || (cmd_i.fill_do && pend_vld_q)) res_q <= res_d;
  end

  always_comb begin
    res_d = '0;
    priority if (cmd_i.emit_ack) begin
      res_d.last = 1'b1;
    end else if (cmd_i.emit_fin) begin
      if (pend_vld_q) begin
        res_d = pend_q;
      end else begin
        res_d.taker_ident = in_q.ident;
      end
      res_d.left_over = rem_q;
      res_d.last      = 1'b1;
    end else begin
      res_d = pend_q;
    end
  end

  assign result_o    = res_q;
  assign res_valid_o = strobe_q;

  // Status toward the controller.
  always_comb begin
    stat_o           = '0;
    stat_o.clr_done  = (clr_q == LW'(LVL_DEPTH - 1));
    stat_o.is_match  = (item_i.op == OP_MATCH);
    stat_o.add_ok    = (32'(in_q.price) < 32'(TICK_COUNT)) &&
                       (32'(in_q.slot) < 32'(NODE_COUNT));
    stat_o.tail_null = (lt_q >= EMPTY_PTR);
    stat_o.rem_zero  = (rem_q == '0);
    stat_o.n_full    = (cnt_q >= CW'(FILL_LIMIT));
    stat_o.word_nz   = (scan_v != '0);
    stat_o.crosses   = (in_q.side == SIDE_BID) ? !(32'(t_scan) > 32'(in_q.price))
                                               : !(32'(t_scan) < 32'(in_q.price));
    stat_o.scan_last = (scan_q == SW'(WPS - 1));
    stat_o.head_null = (lh_q >= EMPTY_PTR);
    stat_o.cont      = full && !nx_null && (rem_d != '0) &&
                       (32'(cnt_inc) < 32'(FILL_LIMIT));
  end

endmodule

`default_nettype wire

@@ design/order_book_price_time_matcher_unit.sv @@
// An add reads its level, writes and links the node, then answers; one out of range answers
// at once. A match scans the bitmap word by word, visits levels, fills head orders one by one
// and closes. Throughput: one item at a time; busy_o stays high until the final result.
// The sweep is bound by the scan of the occupancy bitmap and the single-port level/node stores.
// After reset all 2*TICK_COUNT level entries are cleared one by one, busy_o high meanwhile.
// Results are shown for one cycle on res_valid_o; the receiver cannot stall them.
`default_nettype none

module order_book_price_time_matcher_unit #(
  parameter int TICK_COUNT = obptm_pkg::TICK_COUNT_DEF,
  parameter int NODE_COUNT = obptm_pkg::NODE_COUNT_DEF,
  parameter int FILL_LIMIT = obptm_pkg::FILL_LIMIT_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  obptm_pkg::in_item_t  item_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output obptm_pkg::res_item_t result_o
);
  import obptm_pkg::*;

  // The controller sequences each item; the datapath holds the book, the
  // bitmap scan, the fill arithmetic and the result registers.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  obptm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // A fill is held one step so that the final one can carry the leftover
  // quantity and the last flag once the sweep knows it has ended.
  obptm_dp #(
    .TICK_COUNT (TICK_COUNT),
    .NODE_COUNT (NODE_COUNT),
    .FILL_LIMIT (FILL_LIMIT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o),
    .res_valid_o (res_valid_o)
  );

endmodule

`default_nettype wire

@@ design/obptm_checker.sv @@
`default_nettype none

module obptm_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  start_i,
  input wire                  busy_o,
  input wire                  res_valid_o,
  input obptm_pkg::res_item_t result_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transfer did not make the block busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !result_o.fill_valid) |-> result_o.last)
    else $error("result without fill is not the last one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !result_o.fill_valid) |->
      (result_o.fill_amount == '0 && result_o.maker_ident == '0))
    else $error("result without fill carries fill data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !result_o.last) |-> busy_o)
    else $error("item went idle before its final result");

endmodule

bind order_book_price_time_matcher_unit obptm_checker u_obptm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .result_o    (result_o)
);

`default_nettype wire

@@ sim/book_checker.sv @@
`timescale 1ns / 100ps

module book_checker (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire                  busy_i,
  input  obptm_pkg::in_item_t  item_i,
  input  wire                  res_valid_i,
  input  obptm_pkg::res_item_t result_i,
  output int                   error_count_o,
  output int                   pending_o
);
  import obptm_pkg::*;

  localparam int TICKS = 1024;
  localparam int NODES = 4096;
  localparam int FILL_MAX = 64;
  localparam int WORDS = TICKS / 64;
  localparam logic [12:0] NO_NODE = 13'(NODES);

  logic [63:0] occ_map [2*WORDS];
  logic [12:0] lvl_first [2*TICKS];
  logic [12:0] lvl_last [2*TICKS];
  logic [12:0] lvl_count [2*TICKS];
  logic [43:0] lvl_qty [2*TICKS];
  logic [31:0] ord_qty [NODES];
  logic [31:0] ord_id [NODES];
  logic [12:0] ord_next [NODES];

  res_item_t fills_due [$];

  assign pending_o = fills_due.size();

  function automatic void mark_tick(logic sd, int t, logic on);
    occ_map[sd*WORDS + t/64][t%64] = on;
  endfunction

  // Best tick on side sd: highest for bids being hit, lowest for asks.
  function automatic bit find_best(logic sd, bit want_high, output int t);
    int w;
    int b;
    for (int i = 0; i < WORDS; i++) begin
      w = want_high ? WORDS - 1 - i : i;
      if (occ_map[sd*WORDS + w] != 0) begin
        for (int j = 0; j < 64; j++) begin
          b = want_high ? 63 - j : j;
          if (occ_map[sd*WORDS + w][b]) begin
            t = w*64 + b;
            return 1;
          end
        end
      end
    end
    return 0;
  endfunction

  task automatic book_item(input in_item_t it);
    res_item_t r;
    logic ms;
    logic [31:0] rest;
    logic [31:0] qty;
    logic [31:0] fq;
    int n;
    int t;
    int li;
    int h;
    logic [12:0] nx;
    bit stop;
    r = '0;
    if (it.op == OP_ADD) begin
      li = it.side*TICKS + it.price;
      ord_qty[it.slot] = it.amount;
      ord_id[it.slot] = it.ident;
      ord_next[it.slot] = NO_NODE;
      if (lvl_last[li] >= NO_NODE) lvl_first[li] = 13'(it.slot);
      else ord_next[lvl_last[li]] = 13'(it.slot);
      lvl_last[li] = 13'(it.slot);
      lvl_count[li] = lvl_count[li] + 13'd1;
      lvl_qty[li] = lvl_qty[li] + 44'(it.amount);
      mark_tick(it.side, it.price, 1'b1);
      r.last = 1'b1;
      fills_due.push_back(r);
      return;
    end
    ms = ~it.side;
    rest = it.amount;
    n = 0;
    stop = 0;
    while (!stop && rest > 0 && n < FILL_MAX) begin
      if (!find_best(ms, it.side == SIDE_ASK, t)) break;
      if (it.side == SIDE_BID ? t > it.price : t < it.price) break;
      li = ms*TICKS + t;
      if (lvl_first[li] >= NO_NODE) begin
        // Stale mark: clear it and look again.
        lvl_last[li] = NO_NODE;
        mark_tick(ms, t, 1'b0);
        continue;
      end
      while (rest > 0 && n < FILL_MAX && lvl_first[li] < NO_NODE) begin
        h = lvl_first[li];
        qty = ord_qty[h];
        if (qty <= rest) begin
          nx = ord_next[h];
          fq = qty;
          rest -= fq;
          lvl_first[li] = nx;
          lvl_count[li] = lvl_count[li] - 13'd1;
          lvl_qty[li] = lvl_qty[li] - 44'(fq);
          ord_next[h] = NO_NODE;
          if (nx == NO_NODE) begin
            lvl_last[li] = NO_NODE;
            mark_tick(ms, t, 1'b0);
          end
        end else begin
          fq = rest;
          rest = 0;
          ord_qty[h] = qty - fq;
          lvl_qty[li] = lvl_qty[li] - 44'(fq);
        end
        r = '0;
        r.fill_valid = 1'b1;
        r.maker_ident = ord_id[h];
        r.taker_ident = it.ident;
        r.fill_price = PRICE_W'(t);
        r.fill_amount = fq;
        fills_due.push_back(r);
        n++;
      end
    end
    if (n == 0) begin
      r = '0;
      r.taker_ident = it.ident;
      r.left_over = rest;
      r.last = 1'b1;
      fills_due.push_back(r);
    end else begin
      fills_due[$].left_over = rest;
      fills_due[$].last = 1'b1;
    end
  endtask

  initial begin
    for (int i = 0; i < 2*WORDS; i++) occ_map[i] = '0;
    for (int i = 0; i < 2*TICKS; i++) begin
      lvl_first[i] = NO_NODE;
      lvl_last[i] = NO_NODE;
      lvl_count[i] = '0;
      lvl_qty[i] = '0;
    end
    for (int i = 0; i < NODES; i++) begin
      ord_qty[i] = '0;
      ord_id[i] = '0;
      ord_next[i] = '0;
    end
    error_count_o = 0;
  end

  // Results are compared before the item of the same edge is predicted; an item
  // can only be taken while busy is low, so no result of it is due yet.
  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni) begin
      if (res_valid_i) begin
        if (fills_due.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result_i);
          error_count_o++;
        end else begin
          want = fills_due.pop_front();
          if (want !== result_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, result_i);
            error_count_o++;
          end
        end
      end
      if (start_i && !busy_i) book_item(item_i);
    end
  end
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import obptm_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_item_t item_i;
  logic busy_o;
  logic res_valid_o;
  res_item_t result_o;
  int error_count;
  int pending;
  int idle_pct;
  int quiet_cycles;

  order_book_price_time_matcher_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .item_i(item_i),
    .busy_o(busy_o), .res_valid_o(res_valid_o), .result_o(result_o)
  );

  book_checker checker_0 (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_i(busy_o),
    .item_i(item_i), .res_valid_i(res_valid_o), .result_i(result_o),
    .error_count_o(error_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The watchdog counts cycles without any transfer. Its limit must cover the clearing
  // pass after reset and a full sweep of 64 fills.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Hands one item to the block: optional idle cycles first, then start is
  // held until the edge at which busy is low. Start stays high afterwards so
  // that the next call alone decides its level; the caller drops it at the end.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic in_item_t make_item(logic op, logic sd, int pr, logic [31:0] amt,
                                          logic [11:0] sl);
    in_item_t it;
    it.op = op;
    it.side = sd;
    it.price = PRICE_W'(pr);
    it.amount = amt;
    it.ident = {$urandom()};
    it.slot = sl;
    return it;
  endfunction

  // Prices are drawn around a crossing band so most matches find makers;
  // some go to the far edges of the tick range.
  function automatic int pick_price();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return 1023;
    if (r < 15) return $urandom_range(1023);
    return 500 + $urandom_range(23);
  endfunction

  function automatic logic [31:0] pick_amount();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'hFFFF_FFFF;
    if (r < 10) return {$urandom()};
    if (r < 14) return 32'd0;
    return 32'($urandom_range(1, 60));
  endfunction

  initial begin
    in_item_t it;
    int phase_len;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    idle_pct = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extremes of the fields and every special case.
    send_item(make_item(OP_MATCH, SIDE_BID, 1023, 32'd5, 12'd0));        // empty book
    send_item(make_item(OP_MATCH, SIDE_ASK, 0, 32'd0, 12'hFFF));         // zero amount
    send_item(make_item(OP_ADD, SIDE_ASK, 0, 32'hFFFF_FFFF, 12'd0));
    send_item(make_item(OP_ADD, SIDE_ASK, 0, 32'd0, 12'd1));             // zero order
    send_item(make_item(OP_ADD, SIDE_ASK, 1023, 32'd7, 12'hFFF));
    send_item(make_item(OP_ADD, SIDE_BID, 1023, 32'd3, 12'd2));
    send_item(make_item(OP_ADD, SIDE_BID, 0, 32'd9, 12'd3));
    send_item(make_item(OP_MATCH, SIDE_BID, 0, 32'd10, 12'd0));          // partial
    send_item(make_item(OP_MATCH, SIDE_BID, 1023, 32'hFFFF_FFFF, 12'd0));
    send_item(make_item(OP_MATCH, SIDE_ASK, 1023, 32'd1, 12'd0));        // crosses the bid at 1023
    send_item(make_item(OP_MATCH, SIDE_ASK, 0, 32'd20, 12'd0));
    send_item(make_item(OP_ADD, SIDE_ASK, 600, 32'd4, 12'd10));
    send_item(make_item(OP_ADD, SIDE_ASK, 600, 32'd4, 12'd10));          // slot reuse
    // More than the fill limit rests at one tick.
    for (int i = 0; i < 70; i++)
      send_item(make_item(OP_ADD, SIDE_BID, 100, 32'd1, 12'(100 + i)));
    send_item(make_item(OP_MATCH, SIDE_ASK, 0, 32'd1000, 12'd0));
    send_item(make_item(OP_MATCH, SIDE_ASK, 0, 32'd1000, 12'd0));
    send_item(make_item(OP_MATCH, SIDE_BID, 1023, 32'd100, 12'd0));

    // Random part in idling phases; slots from 200 up are used for random adds.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 48;
        2: idle_pct = 0;
        default: idle_pct = 11;
      endcase
      for (int i = 0; i < 70; i++) begin
        if ($urandom_range(99) < 62)
          it = make_item(OP_ADD, 1'($urandom()), pick_price(), pick_amount(),
                         12'($urandom_range(200, 4095)));
        else
          it = make_item(OP_MATCH, 1'($urandom()), pick_price(), pick_amount(), 12'($urandom()));
        send_item(it);
      end
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
